@@ src/swm_pkg.sv @@
// Shared constants for the sliding window maximum block.
package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_BITS  = 7;
    localparam int OUT_BITS  = 16;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;

    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd1;

    // register index as seen on paddr[ADDR_BITS-1:2]
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

endpackage

@@ src/swm_cell.sv @@
// One cell of the window row: holds a sample and a running maximum.
module swm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int WIN_BITS    = 7,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [WIN_BITS-1:0]    i_win,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_acc,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic [SAMPLE_BITS-1:0] o_acc
);

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_acc;
    logic [SAMPLE_BITS-1:0] n_acc;
    logic                   w_incl;

    assign w_incl = (WIN_BITS'(IDX) < i_win);

    always_comb begin
        n_acc = i_acc;
        if (w_incl && (r_sample > i_acc)) begin
            n_acc = r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
        r_acc <= n_acc;
    end

    assign o_sample = r_sample;
    assign o_acc    = r_acc;

endmodule

@@ src/swm_cfg.sv @@
// Configuration register port and effective window size.
module swm_cfg #(
    parameter int WINDOW_MAX = 64,
    parameter int WIN_BITS   = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [swm_pkg::DATA_BITS-1:0] pwdata,
    output logic [swm_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output logic [WIN_BITS-1:0]           o_win
);

    import swm_pkg::*;

    localparam int CW = (WIN_BITS > CFG_BITS) ? WIN_BITS : CFG_BITS;

    logic [CFG_BITS-1:0] r_window_size;
    logic [CW-1:0]       w_ext;
    logic [CW-1:0]       w_eff;
    logic                w_sel;

    assign w_sel  = (paddr[ADDR_BITS-1:2] == REG_WINDOW_SIZE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
        end else if (psel && penable && pwrite && w_sel) begin
            r_window_size <= pwdata[CFG_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel) begin
            prdata = DATA_BITS'(r_window_size);
        end
    end

    always_comb begin
        w_ext = CW'(r_window_size);
        if (w_ext == '0) begin
            w_eff = CW'(1);
        end else if (w_ext > CW'(WINDOW_MAX)) begin
            w_eff = CW'(WINDOW_MAX);
        end else begin
            w_eff = w_ext;
        end
    end

    assign o_win = w_eff[WIN_BITS-1:0];

endmodule

@@ src/sliding_window_maximum.sv @@
// Sliding window maximum: top level with the cell row and item control.
// Each accepted item shifts into a row of WINDOW_MAX cells; a compare wave
// then ripples down the row, one cell per cycle, so an item occupies the
// block from acceptance until the wave reaches the end and its result (if any)
// is loaded into the output register. o_ready returns high as soon as the
// result is loaded, so the next item is taken while that result still waits
// for i_ready. A result leaves only once at least window_size samples of the
// current array have arrived; an item with i_last_of_array set ends the array
// and starts the next one empty. Write window_size only while idle.
module sliding_window_maximum #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [swm_pkg::DATA_BITS-1:0] pwdata,
    output logic [swm_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic                          i_last_of_array,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [swm_pkg::OUT_BITS-1:0]  o_window_max,
    output logic                          o_array_done
);

    import swm_pkg::*;

    localparam int WIN_BITS = $clog2(WINDOW_MAX + 1);

    logic [WIN_BITS-1:0]    w_win;
    logic [SAMPLE_BITS-1:0] w_samp [WINDOW_MAX+1];
    logic [SAMPLE_BITS-1:0] w_acc  [WINDOW_MAX+1];
    logic                   w_accept;
    logic                   w_done;
    logic [WIN_BITS-1:0]    w_fill_inc;

    logic                   r_busy;
    logic [WIN_BITS-1:0]    r_cnt;
    logic [WIN_BITS-1:0]    r_fill;
    logic                   r_out_valid;
    logic                   r_produce;
    logic                   r_last;
    logic [SAMPLE_BITS-1:0] r_out_max;
    logic                   r_out_done;

    logic                   n_busy;
    logic [WIN_BITS-1:0]    n_cnt;
    logic [WIN_BITS-1:0]    n_fill;
    logic                   n_out_valid;

    swm_cfg #(
        .WINDOW_MAX (WINDOW_MAX),
        .WIN_BITS   (WIN_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_win   (w_win)
    );

    assign w_samp[0] = i_sample;
    assign w_acc[0]  = '0;

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WIN_BITS    (WIN_BITS),
            .IDX         (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_accept),
            .i_win    (w_win),
            .i_sample (w_samp[k]),
            .i_acc    (w_acc[k]),
            .o_sample (w_samp[k+1]),
            .o_acc    (w_acc[k+1])
        );
    end

    assign o_ready    = !r_busy;
    assign w_accept   = i_valid && !r_busy;
    assign w_fill_inc = (r_fill == WIN_BITS'(WINDOW_MAX)) ? r_fill : r_fill + 1'b1;
    assign w_done     = r_busy && (r_cnt == WIN_BITS'(WINDOW_MAX))
                        && (!r_produce || !r_out_valid || i_ready);

    always_comb begin
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_fill = i_last_of_array ? '0 : w_fill_inc;
        end else if (r_busy && (r_cnt != WIN_BITS'(WINDOW_MAX))) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (w_done) begin
            n_busy = 1'b0;
            if (r_produce) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_produce <= (w_fill_inc >= w_win);
            r_last    <= i_last_of_array;
        end
        if (w_done && r_produce) begin
            r_out_max  <= w_acc[WINDOW_MAX];
            r_out_done <= r_last;
        end
    end

    if (SAMPLE_BITS >= OUT_BITS) begin : g_out_trunc
        assign o_window_max = r_out_max[OUT_BITS-1:0];
    end else begin : g_out_ext
        assign o_window_max = OUT_BITS'(r_out_max);
    end

    assign o_valid      = r_out_valid;
    assign o_array_done = r_out_done;

endmodule

@@ src/swm_checker.sv @@
// Port-level checks for the sliding window maximum block, with bind.
module swm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [swm_pkg::OUT_BITS-1:0] o_window_max,
    input logic                         o_array_done
);

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held high after an item was taken");

    a_result_after_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without an item in progress");

    a_result_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_window_max)
                                && $stable(o_array_done))
        else $error("stalled result changed");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_window_max (o_window_max),
    .o_array_done (o_array_done)
);

@@ test/tb_sliding_window_maximum.sv @@
// Testbench for the sliding window maximum block: directed rows, then randomized array traffic.
module tb_sliding_window_maximum;
    import swm_pkg::*;

    localparam int WMAX  = WINDOW_MAX_DEF;
    localparam int SBITS = SAMPLE_BITS_DEF;
    localparam logic [ADDR_BITS-1:0] WIN_ADDR = {REG_WINDOW_SIZE, 2'b00};
    localparam int SETTLE_CYCLES = WMAX + 20;

    typedef struct {
        logic [OUT_BITS-1:0] peak;
        logic                done;
    } win_result_t;

    typedef struct {
        int                  win;
        logic [SBITS-1:0]    sample;
        logic                last;
        bit                  typed;
        logic [OUT_BITS-1:0] peak;
        logic                done;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 i_valid;
    logic                 o_ready;
    logic [SBITS-1:0]     i_sample;
    logic                 i_last_of_array;
    logic                 o_valid;
    logic                 i_ready;
    logic [OUT_BITS-1:0]  o_window_max;
    logic                 o_array_done;

    // predictor state
    logic [SBITS-1:0]    hist [WMAX];
    int unsigned         fill;
    logic [CFG_BITS-1:0] win_reg;

    win_result_t pending_results [$];
    int          mismatches = 0;
    int          tx_idle_max = 0;
    int          rx_idle_max = 0;
    int          rx_wait = 0;
    int          hold_left = 0;

    dir_row_t dir_rows [21] = '{
        '{-1, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{-1, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
        '{-1, 16'h0001, 1'b1, 1'b1, 16'h0001, 1'b1},
        '{ 0, 16'h8000, 1'b0, 1'b1, 16'h8000, 1'b0},
        '{-1, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b1},
        '{ 3, 16'h0010, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0020, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0005, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0009, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{ 4, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0004, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ 6, 16'h0005, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0006, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{-1, 16'h0007, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{65, 16'h1234, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{64, 16'hAAAA, 1'b1, 1'b0, 16'h0000, 1'b0}
    };

    sliding_window_maximum dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic bit predict_window_max(input logic [SBITS-1:0] s, input logic last,
                                              output win_result_t res);
        int unsigned         w;
        logic [SBITS-1:0]    best;
        w = (win_reg == 0) ? 1 : ((win_reg > WMAX) ? WMAX : int'(win_reg));
        for (int k = WMAX - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = s;
        if (fill < WMAX)
            fill++;
        predict_window_max = 1'b0;
        res = '{peak: '0, done: 1'b0};
        if (fill >= w) begin
            best = '0;
            for (int k = 0; k < w; k++)
                if (hist[k] > best)
                    best = hist[k];
            res.peak = OUT_BITS'(best);
            res.done = last;
            predict_window_max = 1'b1;
        end
        if (last) begin
            foreach (hist[k])
                hist[k] = '0;
            fill = 0;
        end
    endfunction

    function automatic logic [SBITS-1:0] rand_sample();
        case ($urandom % 8)
            0: rand_sample = '0;
            1: rand_sample = '1;
            2, 3: rand_sample = SBITS'($urandom_range(0, 15));
            default: rand_sample = SBITS'($urandom);
        endcase
    endfunction

    function automatic int pick_idle_max();
        case ($urandom % 3)
            0: pick_idle_max = 0;
            1: pick_idle_max = 3;
            default: pick_idle_max = 12;
        endcase
    endfunction

    // called right after an acceptance edge or at a falling edge
    task automatic send_item(input logic [SBITS-1:0] s, input logic last, input bit typed,
                             input logic [OUT_BITS-1:0] t_peak, input logic t_done);
        int          gap;
        win_result_t res;
        gap = $urandom_range(0, tx_idle_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample        <= s;
        i_last_of_array <= last;
        do @(posedge i_clk); while (!o_ready);
        if (predict_window_max(s, last, res) || typed) begin
            if (typed)
                res = '{peak: t_peak, done: t_done};
            pending_results.push_back(res);
        end
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        stop_items();
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // let the last item ripple through even if it gave no result
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_BITS-1:0] v);
        logic [DATA_BITS-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIN_ADDR;
        pwdata  <= DATA_BITS'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_BITS-1:0] !== v)
            report($sformatf("window_size read %0d, wrote %0d", rd[CFG_BITS-1:0], v));
        win_reg = v;
    endtask

    // receiver: hold off, per-result stall, else ready
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        win_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result peak=%h done=%b",
                                 o_window_max, o_array_done));
            end else begin
                want = pending_results.pop_front();
                if (o_window_max !== want.peak)
                    report($sformatf("window_max %h, want %h", o_window_max, want.peak));
                if (o_array_done !== want.done)
                    report($sformatf("array_done %b, want %b", o_array_done, want.done));
            end
            rx_wait = $urandom_range(0, rx_idle_max);
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int                  phase_win [12];
        logic [CFG_BITS-1:0] wv;
        int                  w;
        int                  carry;
        int                  sent;
        int                  pick;

        phase_win       = '{1, 127, 2, 64, 0, 65, -1, -1, -1, -1, 5, 3};
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_valid         = 1'b0;
        i_sample        = '0;
        i_last_of_array = 1'b0;
        i_ready         = 1'b0;
        foreach (hist[k])
            hist[k] = '0;
        fill    = 0;
        win_reg = WINDOW_SIZE_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_max = 12;
        rx_idle_max = 12;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].win >= 0) begin
                wait_idle();
                write_window(CFG_BITS'(dir_rows[i].win));
            end
            send_item(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].peak, dir_rows[i].done);
        end

        // arrays run across phase boundaries, so the window also changes mid-array
        carry = 0;
        for (int p = 0; p < 12; p++) begin
            wait_idle();
            tx_idle_max = pick_idle_max();
            rx_idle_max = pick_idle_max();
            if (phase_win[p] < 0)
                wv = CFG_BITS'($urandom_range(1, ($urandom % 2) ? 8 : WMAX));
            else
                wv = CFG_BITS'(phase_win[p]);
            write_window(wv);
            w = (wv == 0) ? 1 : ((wv > WMAX) ? WMAX : int'(wv));
            if (p == 2)
                hold_left = 500;
            sent = 0;
            while (sent < 120) begin
                if (carry == 0) begin
                    pick = $urandom % 20;
                    if (pick < 13)
                        carry = $urandom_range(w, w + 15);
                    else if (pick < 17)
                        carry = $urandom_range(1, (w > 1) ? w - 1 : 1);
                    else
                        carry = $urandom_range(60, 90);
                end
                send_item(rand_sample(), carry == 1, 1'b0, '0, 1'b0);
                carry--;
                sent++;
                if (p == 4 && sent == 60)
                    wait_drain();
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
